[hdl/pctt_pkg.sv]
// Shared types, constants and arithmetic helpers for the color temperature tint block.
`timescale 1ns / 1ps
package pctt_pkg;

  localparam int FRAC_W = 14;
  localparam int QUO_W  = 14;
  localparam int DIV_W  = 8;

  localparam logic [FRAC_W-1:0] FRAC_ONE  = 14'd8192;
  localparam logic [FRAC_W-1:0] FRAC_HALF = 14'd4096;
  localparam logic [14:0]       SUM_FULL  = 15'd16384;

  localparam logic signed [21:0] HUE_SECTOR1 = 22'sd8192;
  localparam logic signed [21:0] HUE_SECTOR2 = 22'sd16384;
  localparam logic signed [21:0] HUE_MID     = 22'sd24576;
  localparam logic signed [21:0] HUE_SECTOR4 = 22'sd32768;

  localparam logic signed [23:0] CLAMP_HIGH = 24'sd7710;
  localparam logic [7:0]         CHAN_MAX   = 8'd255;

  localparam logic [1:0] REG_TINT_RED   = 2'd0;
  localparam logic [1:0] REG_TINT_GREEN = 2'd1;
  localparam logic [1:0] REG_TINT_BLUE  = 2'd2;

  typedef logic [FRAC_W-1:0] frac_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    frac_t             lumi;
    frac_t             dnum;
    logic [DIV_W-1:0]  sdiv;
    logic [DIV_W-1:0]  hdiv;
    frac_t             hnum;
    logic              hneg;
    sector_t           sector;
    logic              grey;
  } work_t;

  // floor(c * 8192 / 255) = 32c + floor(32c / 255)
  function automatic frac_t to_frac(input logic [7:0] c);
    logic [13:0] x;
    logic [13:0] t;
    x = {1'b0, c, 5'd0};
    t = x + {8'd0, x[13:8]} + 14'd1;
    return x + {8'd0, t[13:8]};
  endfunction

  function automatic logic [7:0] to_byte(input logic signed [23:0] v);
    logic [20:0] prod;
    prod = 21'(v[12:0]) * 21'd255;
    if (v < 24'sd0) return 8'd0;
    else if (v > CLAMP_HIGH) return CHAN_MAX;
    else return prod[20:13];
  endfunction

  function automatic logic [7:0] grey_byte(input frac_t l);
    logic [21:0] prod;
    prod = 22'(l) * 22'd255;
    return prod[20:13];
  endfunction

endpackage

[hdl/pixel_color_temperature_tint.sv]
// Top level of the lightness-preserving color temperature tint block.
`timescale 1ns / 1ps
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------
//  pixel in  start high, busy low  red_in, green_in, blue_in
//  result    done strobe (1 cyc)   red_out, green_out, blue_out
//  config    wr_en                 wr_index (0 red, 1 green, 2 blue), wr_data
//
//  One pixel per clock is sustained while busy is low. Each transaction passes 21
//  register stages: 2 front stages, 1 queue stage, 14 divider stages (one quotient
//  bit each) and 4 rebuild stages with two multipliers. The accepting edge loads
//  the first of them, and done is the register of the last.
//  Reset (rst, synchronous) empties the pipeline and sets every tint to 255.
//  The result side never stalls, so the back drains the queue every cycle and
//  busy stays low in normal operation; it rises only if QUEUE_DEPTH - 2 entries wait.
//
module pixel_color_temperature_tint #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       done,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data
);

  logic [7:0] tint_red, tint_green, tint_blue;

  // Tint registers; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      tint_red   <= 8'd255;
      tint_green <= 8'd255;
      tint_blue  <= 8'd255;
    end else if (wr_en) begin
      unique case (wr_index)
        pctt_pkg::REG_TINT_RED:   tint_red   <= wr_data;
        pctt_pkg::REG_TINT_GREEN: tint_green <= wr_data;
        pctt_pkg::REG_TINT_BLUE:  tint_blue  <= wr_data;
        default: ;
      endcase
    end
  end

  logic            accept;
  logic            push, q_valid, almost_full;
  pctt_pkg::work_t f_item, q_item, d_item;
  logic            d_valid;
  logic [pctt_pkg::QUO_W-1:0] quo_s, quo_h;

  // Hold off new pixels while the queue has no room for the two front stages.
  assign busy   = almost_full;
  assign accept = start && !busy;

  pctt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .tint_red   (tint_red),
    .tint_green (tint_green),
    .tint_blue  (tint_blue),
    .push       (push),
    .item       (f_item)
  );

  pctt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .wdata       (f_item),
    .pop         (q_valid),
    .rdata       (q_item),
    .not_empty   (q_valid),
    .almost_full (almost_full)
  );

  // Advance the queue head into the divider whenever one is waiting.
  pctt_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (d_valid),
    .out_item  (d_item),
    .quo_s     (quo_s),
    .quo_h     (quo_h)
  );

  pctt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_item   (d_item),
    .quo_s     (quo_s),
    .quo_h     (quo_h),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  // Transactions in flight, for the checks below.
  logic [5:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 6'(accept) - 6'(done);
    end
  end

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    done |-> (inflight != '0))
    else $error("result strobe with no transaction in flight");

  a_inflight_bounded: assert property (@(posedge clk) disable iff (rst)
    inflight <= 6'd40)
    else $error("transactions in flight exceed pipeline capacity");

  a_queue_never_backs_up: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("queue backed up although the back never stalls");

  a_push_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 push)
    else $error("accepted pixel did not reach the queue");

endmodule

[hdl/pctt_front.sv]
// Front end: frac conversion, tint blend and HSL classification of each pixel.
`timescale 1ns / 1ps
module pctt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  input  logic [7:0]          tint_red,
  input  logic [7:0]          tint_green,
  input  logic [7:0]          tint_blue,
  output logic                push,
  output pctt_pkg::work_t     item
);

  logic            v1;
  pctt_pkg::frac_t lumi1, br1, bg1, bb1;

  pctt_pkg::frac_t fr, fg, fb, fmx, fmn;
  logic [14:0]     fsum, bl_r, bl_g, bl_b;

  always_comb begin
    fr = pctt_pkg::to_frac(red_in);
    fg = pctt_pkg::to_frac(green_in);
    fb = pctt_pkg::to_frac(blue_in);
    fmx = (fr > fg) ? fr : fg;
    fmx = (fmx > fb) ? fmx : fb;
    fmn = (fr < fg) ? fr : fg;
    fmn = (fmn < fb) ? fmn : fb;
    fsum = 15'(fmx) + 15'(fmn);
    bl_r = 15'(pctt_pkg::to_frac(tint_red)) + 15'(fr);
    bl_g = 15'(pctt_pkg::to_frac(tint_green)) + 15'(fg);
    bl_b = 15'(pctt_pkg::to_frac(tint_blue)) + 15'(fb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    lumi1 <= fsum[14:1];
    br1   <= bl_r[14:1];
    bg1   <= bl_g[14:1];
    bb1   <= bl_b[14:1];
  end

  // Classify the blend: extremes, divisors and hue numerator.
  pctt_pkg::frac_t  mx, mn, d;
  logic [14:0]      sum, rsum;
  logic signed [14:0] diff;
  pctt_pkg::work_t  nxt;

  always_comb begin
    mx = (br1 > bg1) ? br1 : bg1;
    mx = (mx > bb1) ? mx : bb1;
    mn = (br1 < bg1) ? br1 : bg1;
    mn = (mn < bb1) ? mn : bb1;
    sum  = 15'(mx) + 15'(mn);
    rsum = pctt_pkg::SUM_FULL - sum;
    d = mx - mn;
    nxt.lumi = lumi1;
    nxt.dnum = d;
    nxt.sdiv = (sum[14:1] <= pctt_pkg::FRAC_HALF) ? sum[14:7] : rsum[14:7];
    nxt.hdiv = {1'b0, d[13:7]};
    if (mx == br1) begin
      nxt.sector = pctt_pkg::SEC_RED;
      diff = $signed({1'b0, bg1}) - $signed({1'b0, bb1});
    end else if (mx == bg1) begin
      nxt.sector = pctt_pkg::SEC_GREEN;
      diff = $signed({1'b0, bb1}) - $signed({1'b0, br1});
    end else begin
      nxt.sector = pctt_pkg::SEC_BLUE;
      diff = $signed({1'b0, br1}) - $signed({1'b0, bg1});
    end
    nxt.hneg = diff[14];
    nxt.hnum = diff[14] ? 14'(-diff) : diff[13:0];
    nxt.grey = (mx == mn) || (nxt.sdiv == '0) || (nxt.hdiv == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v1;
    end
    item <= nxt;
  end

endmodule

[hdl/pctt_queue.sv]
// Short queue between the classifying front and the arithmetic back.
`timescale 1ns / 1ps
module pctt_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pctt_pkg::work_t wdata,
  input  logic            pop,
  output pctt_pkg::work_t rdata,
  output logic            not_empty,
  output logic            almost_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pctt_pkg::work_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_pop;

  assign do_pop      = pop && (count != '0);
  assign not_empty   = (count != '0);
  assign almost_full = (count >= CW'(DEPTH - 2));
  assign rdata       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

[hdl/pctt_divider.sv]
// Pipelined restoring divider: saturation and hue quotients, one bit per stage.
`timescale 1ns / 1ps
module pctt_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  pctt_pkg::work_t             in_item,
  output logic                        out_valid,
  output pctt_pkg::work_t             out_item,
  output logic [pctt_pkg::QUO_W-1:0]  quo_s,
  output logic [pctt_pkg::QUO_W-1:0]  quo_h
);

  localparam int N = pctt_pkg::QUO_W;

  logic                       v  [1:N];
  pctt_pkg::work_t            w  [1:N];
  logic [pctt_pkg::DIV_W-1:0] rs [1:N];
  logic [pctt_pkg::DIV_W-1:0] rh [1:N];
  logic [N-1:0]               qs [1:N];
  logic [N-1:0]               qh [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                       pv;
    pctt_pkg::work_t            pw;
    logic [pctt_pkg::DIV_W-1:0] prs, prh;
    logic [N-1:0]               pqs, pqh;
    logic [pctt_pkg::DIV_W:0]   ts, th;
    logic                       ges, geh;

    if (i == 0) begin : g_head
      assign pv  = in_valid;
      assign pw  = in_item;
      assign prs = '0;
      assign prh = '0;
      assign pqs = '0;
      assign pqh = '0;
    end else begin : g_body
      assign pv  = v[i];
      assign pw  = w[i];
      assign prs = rs[i];
      assign prh = rh[i];
      assign pqs = qs[i];
      assign pqh = qh[i];
    end

    // Shift in the next numerator bit and try the subtract.
    assign ts  = {prs, pw.dnum[N-1-i]};
    assign th  = {prh, pw.hnum[N-1-i]};
    assign ges = (ts >= {1'b0, pw.sdiv});
    assign geh = (th >= {1'b0, pw.hdiv});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= pv;
      end
      w[i+1]  <= pw;
      rs[i+1] <= ges ? pctt_pkg::DIV_W'(ts - {1'b0, pw.sdiv}) : ts[pctt_pkg::DIV_W-1:0];
      rh[i+1] <= geh ? pctt_pkg::DIV_W'(th - {1'b0, pw.hdiv}) : th[pctt_pkg::DIV_W-1:0];
      qs[i+1] <= {pqs[N-2:0], ges};
      qh[i+1] <= {pqh[N-2:0], geh};
    end
  end

  assign out_valid = v[N];
  assign out_item  = w[N];
  assign quo_s     = qs[N];
  assign quo_h     = qh[N];

endmodule

[hdl/pctt_back.sv]
// Back end: rebuild RGB from blend hue/saturation and the pixel's own lightness.
`timescale 1ns / 1ps
module pctt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  pctt_pkg::work_t             in_item,
  input  logic [pctt_pkg::QUO_W-1:0]  quo_s,
  input  logic [pctt_pkg::QUO_W-1:0]  quo_h,
  output logic                        done,
  output logic [7:0]                  red_out,
  output logic [7:0]                  green_out,
  output logic [7:0]                  blue_out
);

  // Stage 1: saturation, hue, and the product behind q.
  logic signed [20:0] s_sg;
  logic signed [21:0] hmag, h0, mb;
  logic signed [20:0] ma;
  logic               lo0;

  logic               v1, lo1, grey1;
  logic signed [42:0] prod1;
  logic signed [21:0] h1;
  pctt_pkg::frac_t    lumi1;

  always_comb begin
    s_sg = $signed({1'b0, quo_s, 6'd0});
    hmag = $signed({2'b0, quo_h, 6'd0});
    unique case (in_item.sector)
      pctt_pkg::SEC_RED:   h0 = in_item.hneg ? -hmag : hmag;
      pctt_pkg::SEC_GREEN: h0 = (in_item.hneg ? -hmag : hmag) + pctt_pkg::HUE_SECTOR2;
      pctt_pkg::SEC_BLUE:  h0 = (in_item.hneg ? -hmag : hmag) + pctt_pkg::HUE_SECTOR4;
      default:             h0 = '0;
    endcase
    lo0 = (in_item.lumi <= pctt_pkg::FRAC_HALF);
    ma  = lo0 ? $signed({7'd0, in_item.lumi}) : s_sg;
    mb  = lo0 ? (22'sd8192 - 22'(s_sg)) : (22'sd8192 - $signed({8'd0, in_item.lumi}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    lo1   <= lo0;
    grey1 <= in_item.grey || (quo_s == '0);
    prod1 <= 43'(ma) * 43'(mb);
    h1    <= h0;
    lumi1 <= in_item.lumi;
  end

  // Stage 2: q, p, span and the hue offset inside its sector.
  logic signed [19:0] m1, q_c, p_c, lumi_sg;
  logic signed [21:0] t_c;
  pctt_pkg::sector_t  sec_c;

  logic               v2, grey2;
  logic signed [19:0] q2, p2, span2;
  logic signed [21:0] t2;
  pctt_pkg::sector_t  sec2;
  pctt_pkg::frac_t    lumi2;

  always_comb begin
    m1      = 20'(prod1 >>> 13);
    lumi_sg = $signed({6'd0, lumi1});
    q_c     = lo1 ? m1 : lumi_sg - m1;
    p_c     = (lumi_sg <<< 1) - q_c;
    priority if (h1 < pctt_pkg::HUE_SECTOR1) begin
      sec_c = pctt_pkg::SEC_RED;
      t_c   = h1;
    end else if (h1 < pctt_pkg::HUE_MID) begin
      sec_c = pctt_pkg::SEC_GREEN;
      t_c   = h1 - pctt_pkg::HUE_SECTOR2;
    end else begin
      sec_c = pctt_pkg::SEC_BLUE;
      t_c   = h1 - pctt_pkg::HUE_SECTOR4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    grey2 <= grey1;
    q2    <= q_c;
    p2    <= p_c;
    span2 <= p_c - q_c;
    t2    <= t_c;
    sec2  <= sec_c;
    lumi2 <= lumi1;
  end

  // Stage 3: hue offset times span.
  logic               v3, grey3, tneg3;
  logic signed [41:0] prod3;
  logic signed [19:0] q3, p3;
  pctt_pkg::sector_t  sec3;
  pctt_pkg::frac_t    lumi3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    grey3 <= grey2;
    tneg3 <= t2[21];
    prod3 <= 42'(t2) * 42'(span2);
    q3    <= q2;
    p3    <= p2;
    sec3  <= sec2;
    lumi3 <= lumi2;
  end

  // Stage 4: place p, q and the ramp, then clamp to bytes.
  logic signed [23:0] m3, ramp, qx, px, o_r, o_g, o_b;
  logic [7:0]         grey_c;

  always_comb begin
    m3   = 24'(prod3 >>> 13);
    qx   = 24'(q3);
    px   = 24'(p3);
    ramp = tneg3 ? qx - m3 : qx + m3;
    unique case (sec3)
      pctt_pkg::SEC_RED: begin
        o_r = px;
        o_g = tneg3 ? qx : ramp;
        o_b = tneg3 ? ramp : qx;
      end
      pctt_pkg::SEC_GREEN: begin
        o_g = px;
        o_b = tneg3 ? qx : ramp;
        o_r = tneg3 ? ramp : qx;
      end
      pctt_pkg::SEC_BLUE: begin
        o_b = px;
        o_r = tneg3 ? qx : ramp;
        o_g = tneg3 ? ramp : qx;
      end
      default: begin
        o_r = '0;
        o_g = '0;
        o_b = '0;
      end
    endcase
    grey_c = pctt_pkg::grey_byte(lumi3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    red_out   <= grey3 ? grey_c : pctt_pkg::to_byte(o_r);
    green_out <= grey3 ? grey_c : pctt_pkg::to_byte(o_g);
    blue_out  <= grey3 ? grey_c : pctt_pkg::to_byte(o_b);
  end

endmodule
